@@ rtl/rldrv_pkg.sv @@
// Package with shared types, constants and register codes of the RGB LED PWM driver.
package rldrv_pkg;

    localparam int unsigned PWM_PERIOD_US_DEF = 20000;
    localparam int unsigned SINE_DEPTH_DEF    = 256;

    localparam int unsigned DIV_W      = 32;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned LEVEL_W    = 18;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned BRIGHT_W   = 9;
    localparam int unsigned INTERVAL_W = 10;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned SPAN_W     = 17;
    localparam int unsigned T_W        = 23;
    localparam int unsigned F_W        = 10;
    localparam int unsigned MAG_W      = 9;
    localparam int unsigned NUM_SHIFT  = 13;
    localparam int unsigned ALT_SHIFT  = 9;

    localparam int unsigned FULL_Q9     = 255 * 512;
    localparam int unsigned US_PER_MS   = 1000;
    localparam int unsigned F_MID       = 256;
    localparam int unsigned F_FULL      = 512;
    localparam int unsigned BRIGHT_FULL = 256;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LED_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIMARY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECONDARY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_HALF  = 3'd5;

    localparam logic [COLOR_W-1:0]    RST_PRIMARY    = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0]    RST_SECONDARY  = 24'h000000;
    localparam logic [BRIGHT_W-1:0]   RST_BRIGHTNESS = 9'd256;
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL   = 10'd500;
    localparam logic [HALF_W-1:0]     RST_GRAD_HALF  = 16'd1000;

    localparam logic [1:0] CH_RED  = 2'd0;
    localparam logic [1:0] CH_GRN  = 2'd1;
    localparam logic [1:0] CH_LAST = 2'd2;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_STEADY,
        MODE_ALTERNATE,
        MODE_GRADIENT
    } led_mode_t;

    typedef enum logic [4:0] {
        S_FILL,
        S_FILL_WAIT,
        S_IDLE,
        S_T,
        S_Q,
        S_PH,
        S_ALT,
        S_P,
        S_P_WAIT,
        S_IX,
        S_IX_WAIT,
        S_RD,
        S_LVL,
        S_MUL,
        S_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

@@ rtl/rldrv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rldrv_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ rtl/rldrv_div.sv @@
// Shared restoring divider producing one quotient bit per cycle.
module rldrv_div (
    input  logic                clk,
    input  logic                rst_n,
    input  rldrv_pkg::div_req_t req,
    output rldrv_pkg::div_rsp_t rsp
);
    import rldrv_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W:0]   trial;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ rtl/rgb_led_mode_pwm_driver_unit.sv @@
// Top level of the RGB LED mode driver with software PWM on three pins.
//
//  channel   direction  handshake                   payload
//  sample    in         sample_valid/sample_stall   now_us
//  pins      out        pins_valid/pins_stall       red_on, green_on, blue_on
//  config    in         APB psel/penable/pready     paddr, pwdata, prdata
//
// A beat passes S_T, S_Q and S_PH, then S_ALT in alternate mode or S_P, S_IX
// and S_RD in gradient mode, then S_LVL, S_MUL and S_CMP per channel and S_DONE;
// a reciprocal multiplier gives the ms time and the PWM phase, and the shared
// divider the sine index. After reset the sine table RAM is filled, one divide
// per entry; no sample is accepted meanwhile, configuration writes are. A result
// waits in the output register while the next sample is processed.
module rgb_led_mode_pwm_driver_unit #(
    parameter int unsigned PWM_PERIOD_US    = rldrv_pkg::PWM_PERIOD_US_DEF,
    parameter int unsigned SINE_TABLE_DEPTH = rldrv_pkg::SINE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rldrv_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rldrv_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rldrv_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  logic [rldrv_pkg::NOW_W-1:0]      now_us,
    output logic                             pins_valid,
    input  logic                             pins_stall,
    output logic                             red_on,
    output logic                             green_on,
    output logic                             blue_on
);
    import rldrv_pkg::*;

    localparam int unsigned PH_W       = $clog2(PWM_PERIOD_US);
    localparam int unsigned PER_BITS   = $clog2(PWM_PERIOD_US + 1);
    localparam int unsigned PROD_W     = LEVEL_W + PER_BITS;
    localparam int unsigned IDX_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned DEPTH_W    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int unsigned PD_W       = SPAN_W + DEPTH_W;
    localparam int unsigned HALF       = SINE_TABLE_DEPTH / 2;
    localparam int unsigned K_W        = $clog2(HALF + 1);
    localparam int unsigned PK_W       = 2 * K_W;
    localparam int unsigned DEN_FULL   = 5 * HALF * HALF;
    localparam int unsigned DEN_W      = $clog2(DEN_FULL + 1);
    localparam int unsigned RCP_W      = NOW_W + 1;
    localparam int unsigned RCP_PROD_W = NOW_W + RCP_W;
    localparam int unsigned MS_SHIFT   = NOW_W + $clog2(US_PER_MS);
    localparam int unsigned PER_SHIFT  = NOW_W + PH_W;

    localparam logic [RCP_W-1:0] MS_RECIP =
        RCP_W'(((64'd1 << MS_SHIFT) + 64'(US_PER_MS) - 64'd1) / 64'(US_PER_MS));
    localparam logic [RCP_W-1:0] PER_RECIP =
        RCP_W'(((64'd1 << PER_SHIFT) + 64'(PWM_PERIOD_US) - 64'd1) / 64'(PWM_PERIOD_US));

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SINE_TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(HALF);

    function automatic logic [CHAN_W-1:0] chan_sel(input logic [COLOR_W-1:0] c,
                                                   input logic [1:0] sel);
        logic [CHAN_W-1:0] r;
        case (sel)
            CH_RED:  r = c[23:16];
            CH_GRN:  r = c[15:8];
            default: r = c[7:0];
        endcase
        return r;
    endfunction

    led_mode_t            led_mode_reg;
    logic [COLOR_W-1:0]   primary_reg;
    logic [COLOR_W-1:0]   secondary_reg;
    logic [BRIGHT_W-1:0]  brightness_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [HALF_W-1:0]    grad_half_reg;
    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     fill_idx_reg, fill_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           ch_reg, ch_next;
    logic                 showing_reg, showing_next;
    logic [T_W-1:0]       last_reg, last_next;

    logic [NOW_W-1:0]     now_reg, now_next;
    logic [T_W-1:0]       t_reg, t_next;
    logic [NOW_W-1:0]     q_reg, q_next;
    logic [PH_W-1:0]      phase_reg, phase_next;
    logic [SPAN_W-1:0]    p_reg, p_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [PROD_W-1:0]    prod_a_reg, prod_a_next;
    logic [PROD_W-1:0]    prod_b_reg, prod_b_next;
    logic [2:0]           pins_reg, pins_next;
    logic [2:0]           out_reg, out_next;

    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic                 ram_we;
    logic                 ram_re;
    logic [F_W-1:0]       ram_wdata;
    logic [F_W-1:0]       ram_rdata;

    logic [K_W-1:0]       k;
    logic [K_W-1:0]       k_rest;
    logic [PK_W-1:0]      prodk;
    logic [DEN_W-1:0]     den;
    logic [DIV_W-1:0]     fill_dividend;
    logic [DIV_W-1:0]     fill_divisor;
    logic [MAG_W-1:0]     mag;
    logic [HALF_W-1:0]    half_eff;
    logic [SPAN_W-1:0]    span;
    logic [PD_W-1:0]      p_times_d;
    logic                 accept;
    logic                 div_done;
    logic [RCP_W-1:0]     rcp_k;
    logic [RCP_PROD_W-1:0] rcp_prod;
    logic [NOW_W-1:0]     ph_full;

    logic [BRIGHT_W-1:0]  bright_sat;
    logic [CHAN_W-1:0]    cp;
    logic [CHAN_W-1:0]    cs;
    logic [CHAN_W-1:0]    ca;
    logic [LEVEL_W-1:0]   lvl_steady;
    logic [LEVEL_W-1:0]   lvl_alt;
    logic [LEVEL_W-1:0]   lvl_grad;
    logic [T_W-1:0]       lt_fix;
    logic [T_W:0]         lt_sum;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_mode_reg   <= MODE_OFF;
            primary_reg    <= RST_PRIMARY;
            secondary_reg  <= RST_SECONDARY;
            brightness_reg <= RST_BRIGHTNESS;
            interval_reg   <= RST_INTERVAL;
            grad_half_reg  <= RST_GRAD_HALF;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_LED_MODE:   led_mode_reg   <= led_mode_t'(pwdata[MODE_W-1:0]);
                REG_PRIMARY:    primary_reg    <= pwdata[COLOR_W-1:0];
                REG_SECONDARY:  secondary_reg  <= pwdata[COLOR_W-1:0];
                REG_BRIGHTNESS: brightness_reg <= pwdata[BRIGHT_W-1:0];
                REG_INTERVAL:   interval_reg   <= pwdata[INTERVAL_W-1:0];
                REG_GRAD_HALF:  grad_half_reg  <= pwdata[HALF_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_LED_MODE:   prdata = CFG_DATA_W'(led_mode_reg);
            REG_PRIMARY:    prdata = CFG_DATA_W'(primary_reg);
            REG_SECONDARY:  prdata = CFG_DATA_W'(secondary_reg);
            REG_BRIGHTNESS: prdata = CFG_DATA_W'(brightness_reg);
            REG_INTERVAL:   prdata = CFG_DATA_W'(interval_reg);
            REG_GRAD_HALF:  prdata = CFG_DATA_W'(grad_half_reg);
            default:        prdata = '0;
        endcase
    end

    // Sine table entry for the fill index, divided on the shared unit.
    always_comb
    begin
        k             = (fill_idx_reg < HALF_IDX) ? K_W'(fill_idx_reg)
                                                  : K_W'(fill_idx_reg - HALF_IDX);
        k_rest        = K_W'(HALF) - k;
        prodk         = PK_W'(k) * PK_W'(k_rest);
        den           = DEN_W'(DEN_FULL) - (DEN_W'(prodk) << 2);
        fill_dividend = (DIV_W'(prodk) << NUM_SHIFT) + DIV_W'(den);
        fill_divisor  = DIV_W'(den) << 1;
        mag           = div_rsp.quot[MAG_W-1:0];
        ram_wdata     = (fill_idx_reg < HALF_IDX) ? F_W'(F_MID) + F_W'(mag)
                                                  : F_W'(F_MID) - F_W'(mag);
    end

    // Exact quotient by a constant through a rounded-up reciprocal.
    assign rcp_k     = (state_reg == S_T) ? MS_RECIP : PER_RECIP;
    assign rcp_prod  = RCP_PROD_W'(now_reg) * RCP_PROD_W'(rcp_k);
    assign ph_full   = now_reg - q_reg * NOW_W'(PWM_PERIOD_US);

    assign half_eff  = (grad_half_reg == '0) ? HALF_W'(1) : grad_half_reg;
    assign span      = {half_eff, 1'b0};
    assign p_times_d = PD_W'(p_reg) * PD_W'(SINE_TABLE_DEPTH);
    assign accept    = sample_valid && !sample_stall;
    assign div_done  = div_rsp.done;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_FILL:      state_next = S_FILL_WAIT;
            S_FILL_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (fill_idx_reg == IDX_LAST) ? S_IDLE : S_FILL;
                end
            end
            S_IDLE:      state_next = sample_valid ? S_T : S_IDLE;
            S_T:         state_next = S_Q;
            S_Q:         state_next = S_PH;
            S_PH:
            begin
                case (led_mode_reg)
                    MODE_ALTERNATE: state_next = S_ALT;
                    MODE_GRADIENT:  state_next = S_P;
                    default:        state_next = S_LVL;
                endcase
            end
            S_ALT:       state_next = S_LVL;
            S_P:         state_next = S_P_WAIT;
            S_P_WAIT:    state_next = div_done ? S_IX : S_P_WAIT;
            S_IX:        state_next = S_IX_WAIT;
            S_IX_WAIT:   state_next = div_done ? S_RD : S_IX_WAIT;
            S_RD:        state_next = S_LVL;
            S_LVL:       state_next = S_MUL;
            S_MUL:       state_next = S_CMP;
            S_CMP:       state_next = (ch_reg == CH_LAST) ? S_DONE : S_LVL;
            S_DONE:
            begin
                if (!out_valid_reg || !pins_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        sample_stall     = (state_reg != S_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(t_reg);
        div_req.divisor  = DIV_W'(span);
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        case (state_reg)
            S_FILL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = fill_dividend;
                div_req.divisor  = fill_divisor;
            end
            S_FILL_WAIT: ram_we = div_done;
            S_P:         div_req.start = 1'b1;
            S_IX:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(p_times_d);
            end
            S_RD:        ram_re = 1'b1;
            default:     ;
        endcase
    end

    always_comb
    begin
        bright_sat = (brightness_reg > BRIGHT_W'(BRIGHT_FULL)) ? BRIGHT_W'(BRIGHT_FULL)
                                                               : brightness_reg;
        cp         = chan_sel(primary_reg, ch_reg);
        cs         = chan_sel(secondary_reg, ch_reg);
        ca         = showing_reg ? cp : cs;
        lvl_steady = (LEVEL_W'(cp) * LEVEL_W'(bright_sat)) << 1;
        lvl_alt    = LEVEL_W'(ca) << ALT_SHIFT;
        lvl_grad   = LEVEL_W'(cp) * LEVEL_W'(ram_rdata)
                   + LEVEL_W'(cs) * LEVEL_W'(F_W'(F_FULL) - ram_rdata);
        lt_fix     = (last_reg > t_reg) ? t_reg : last_reg;
        lt_sum     = (T_W + 1)'(lt_fix) + (T_W + 1)'(interval_reg);
    end

    always_comb
    begin
        fill_idx_next  = fill_idx_reg;
        out_valid_next = out_valid_reg;
        ch_next        = ch_reg;
        showing_next   = showing_reg;
        last_next      = last_reg;
        now_next       = now_reg;
        t_next         = t_reg;
        q_next         = q_reg;
        phase_next     = phase_reg;
        p_next         = p_reg;
        idx_next       = idx_reg;
        level_next     = level_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        pins_next      = pins_reg;
        out_next       = out_reg;
        if (out_valid_reg && !pins_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_FILL_WAIT:
            begin
                if (div_done && fill_idx_reg != IDX_LAST)
                begin
                    fill_idx_next = fill_idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next = now_us;
                    ch_next  = CH_RED;
                end
            end
            S_T:         t_next = T_W'(rcp_prod >> MS_SHIFT);
            S_Q:         q_next = NOW_W'(rcp_prod >> PER_SHIFT);
            S_PH:        phase_next = ph_full[PH_W-1:0];
            S_ALT:
            begin
                // A backward jump of time restarts the interval from now.
                last_next = lt_fix;
                if (lt_sum < (T_W + 1)'(t_reg))
                begin
                    showing_next = !showing_reg;
                    last_next    = t_reg;
                end
            end
            S_P_WAIT:    p_next = div_rsp.rem[SPAN_W-1:0];
            S_IX_WAIT:
            begin
                idx_next = (div_rsp.quot >= DIV_W'(SINE_TABLE_DEPTH)) ? IDX_LAST
                                                                      : div_rsp.quot[IDX_W-1:0];
            end
            S_LVL:
            begin
                case (led_mode_reg)
                    MODE_STEADY:    level_next = lvl_steady;
                    MODE_ALTERNATE: level_next = lvl_alt;
                    MODE_GRADIENT:  level_next = lvl_grad;
                    default:        level_next = '0;
                endcase
            end
            S_MUL:
            begin
                prod_a_next = PROD_W'(level_reg) * PROD_W'(PWM_PERIOD_US);
                prod_b_next = PROD_W'(phase_reg) * PROD_W'(FULL_Q9);
            end
            S_CMP:
            begin
                pins_next[ch_reg] = prod_a_reg > prod_b_reg;
                ch_next           = ch_reg + 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !pins_stall)
                begin
                    out_next       = pins_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            fill_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            ch_reg        <= CH_RED;
            showing_reg   <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_idx_reg  <= fill_idx_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            showing_reg   <= showing_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        t_reg      <= t_next;
        q_reg      <= q_next;
        phase_reg  <= phase_next;
        p_reg      <= p_next;
        idx_reg    <= idx_next;
        level_reg  <= level_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        pins_reg   <= pins_next;
        out_reg    <= out_next;
    end

    rldrv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rldrv_ram #(
        .WIDTH (F_W),
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign pins_valid = out_valid_reg;
    assign red_on     = out_reg[0];
    assign green_on   = out_reg[1];
    assign blue_on    = out_reg[2];

endmodule

@@ rtl/rldrv_checker.sv @@
// Port-level checker of the RGB LED PWM driver, bound to the top level.
module rldrv_checker (
    input logic clk,
    input logic rst_n,
    input logic psel,
    input logic penable,
    input logic pwrite,
    input logic pready,
    input logic sample_valid,
    input logic sample_stall,
    input logic pins_valid,
    input logic pins_stall,
    input logic red_on,
    input logic green_on,
    input logic blue_on
);

    // A stalled result beat stays valid.
    a_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pins_valid && pins_stall |=> pins_valid)
        else $error("pins beat dropped while stalled");

    // A stalled result beat keeps its pin levels.
    a_pins_stable: assert property (@(posedge clk) disable iff (!rst_n)
        pins_valid && pins_stall |=> $stable({red_on, green_on, blue_on}))
        else $error("pins beat changed while stalled");

    // The block works on one sample at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("sample taken while the previous one is in work");

    // A new result only appears while a sample is being processed.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pins_valid) |-> $past(sample_stall))
        else $error("result beat without a sample in work");

    // A configuration write always completes in its access cycle.
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |-> pready)
        else $error("configuration write not completed");

endmodule

bind rgb_led_mode_pwm_driver_unit rldrv_checker u_rldrv_checker (.*);
